// ----- design/gb5_pkg.sv -----
// Shared types, constants and helper functions for the 5x5 Gaussian blur window.
package gb5_pkg;

    // Sizes
    localparam int unsigned MAX_WIDTH_DEF  = 2048;
    localparam int unsigned MAX_HEIGHT_DEF = 2048;
    localparam int unsigned SIZE_LIMIT     = 2048;
    localparam int unsigned MIN_INTERIOR   = 5;
    localparam int unsigned WIDTH_RESET    = 640;
    localparam int unsigned HEIGHT_RESET   = 480;

    // Field widths
    localparam int CH_W     = 8;
    localparam int CHANNELS = 3;
    localparam int PIX_W    = CH_W * CHANNELS;
    localparam int POS_W    = 11;
    localparam int SIZE_W   = 12;
    localparam int S_TDATA_W = PIX_W;
    localparam int M_TDATA_W = 48;
    localparam int PAD_W     = M_TDATA_W - 2 * POS_W - PIX_W;

    // Arithmetic widths: vertical 1,2,4,2,1 sum of 8-bit values is at most 2550,
    // full 5x5 sum at most 25500
    localparam int VS_W      = 12;
    localparam int HS_W      = 15;
    localparam int TAPS      = 5;
    localparam int LINE_ROWS = 4;

    // floor(x / 100) = (x * 5243) >> 19 for every x below 43690
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = HS_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = 13'd5243;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef logic [CHANNELS-1:0][VS_W-1:0]  vsum_t;
    typedef logic [CHANNELS-1:0][HS_W-1:0]  hsum_t;
    typedef logic [CHANNELS-1:0][CH_W-1:0]  chan_t;
    // Slot 0 holds the row just above, slot 3 the row four above
    typedef logic [LINE_ROWS-1:0][PIX_W-1:0] line_word_t;

    // One pixel travelling down the pipeline
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] pix;
        logic             is_int;  // an interior result falls due
        logic             is_pt;   // the pixel itself passes through
    } item_t;

    // Size after the zero and oversize rules
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input int unsigned maxp);
        int unsigned lim;
        lim = (maxp < SIZE_LIMIT) ? maxp : SIZE_LIMIT;
        if (v == '0) begin
            return SIZE_W'(1);
        end else if (32'(v) > lim) begin
            return SIZE_W'(lim);
        end else begin
            return v;
        end
    endfunction

    // Kernel weight of a tap as a shift: 1,2,4,2,1
    function automatic int tap_shift(input int k);
        if (k == 2) begin
            return 2;
        end else if (k == 1 || k == 3) begin
            return 1;
        end else begin
            return 0;
        end
    endfunction

    // Weighted column sum: newest pixel plus the four stored rows above
    function automatic vsum_t vert_sum(input logic [PIX_W-1:0] pix, input line_word_t word);
        vsum_t res;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            res[ch] = VS_W'(pix[ch*CH_W +: CH_W])
                    + (VS_W'(word[0][ch*CH_W +: CH_W]) << 1)
                    + (VS_W'(word[1][ch*CH_W +: CH_W]) << 2)
                    + (VS_W'(word[2][ch*CH_W +: CH_W]) << 1)
                    + VS_W'(word[3][ch*CH_W +: CH_W]);
        end
        return res;
    endfunction

endpackage

// ----- design/gb5_line_buf.sv -----
// Line store: one word per column holding the four rows above, registered read.
module gb5_line_buf #(
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output gb5_pkg::line_word_t      rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  gb5_pkg::line_word_t      wr_data
);

    gb5_pkg::line_word_t line_mem [DEPTH];
    gb5_pkg::line_word_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/gb5_cell.sv -----
// One horizontal tap of the window: adds its weighted column sum to the partial sum passed in.
module gb5_cell #(
    parameter int TAP_SHIFT = 0
) (
    input  logic           aclk,
    input  logic           en,
    input  gb5_pkg::hsum_t acc_in,
    input  gb5_pkg::vsum_t v_in,
    output gb5_pkg::hsum_t acc_out
);

    gb5_pkg::hsum_t acc_reg;
    gb5_pkg::hsum_t acc_next;

    // Partial sum from the left neighbour plus this tap's share
    always_comb begin
        for (int ch = 0; ch < gb5_pkg::CHANNELS; ch++) begin
            acc_next[ch] = acc_in[ch] + (gb5_pkg::HS_W'(v_in[ch]) << TAP_SHIFT);
        end
    end

    // Moves only when a new column enters the window
    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc_out = acc_reg;

endmodule

// ----- design/gb5_scale.sv -----
// Divide-by-100 stage: multiply by the reciprocal and register the quotient per channel.
module gb5_scale (
    input  logic           aclk,
    input  logic           en,
    input  gb5_pkg::hsum_t sum_in,
    output gb5_pkg::chan_t quo_out
);

    logic [gb5_pkg::CHANNELS-1:0][gb5_pkg::PROD_W-1:0] prod;
    gb5_pkg::chan_t quo_reg;

    // Reciprocal multiply, one per channel
    always_comb begin
        for (int ch = 0; ch < gb5_pkg::CHANNELS; ch++) begin
            prod[ch] = gb5_pkg::PROD_W'(sum_in[ch]) * gb5_pkg::PROD_W'(gb5_pkg::RECIP);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int ch = 0; ch < gb5_pkg::CHANNELS; ch++) begin
                quo_reg[ch] <= prod[ch][gb5_pkg::RECIP_SHIFT +: gb5_pkg::CH_W];
            end
        end
    end

    assign quo_out = quo_reg;

endmodule

// ----- design/gaussian_blur_5x5_window.sv -----
// 5x5 Gaussian blur over a raster pixel stream: top level with counters, pipeline and output.
//
// Takes one pixel per clock in raster order while the output accepts and no pixel gives two
// results. The line store is read as each pixel is accepted and written back as it leaves the
// first stage, when the column sum enters a row of five tap cells. A pixel's first result is
// presented after the line store read, the tap cells and the divide stage. A pixel that both
// passes through and completes an interior result (near the right and bottom edges) gives two
// results and holds the output until both are taken; others give one or none. The line store
// is a single memory of min(MAX_WIDTH, 2048) words of four pixels each, not cleared after
// reset. A mapped register write restarts at row 0, column 0 and keeps the stored rows.
module gaussian_blur_5x5_window #(
    parameter int unsigned MAX_WIDTH  = gb5_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = gb5_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Pixel input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gb5_pkg::S_TDATA_W-1:0]   s_tdata,   // pix_blue, pix_green, pix_red
    // Results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gb5_pkg::M_TDATA_W-1:0]   m_tdata,   // out_row, out_col, out_blue,
                                                       // out_green, out_red, zero pad
    output logic                            m_tlast,   // last_of_run
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gb5_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gb5_pkg::SIZE_W-1:0]      cfg_data
);

    localparam int unsigned LINE_DEPTH = (MAX_WIDTH < gb5_pkg::SIZE_LIMIT) ?
                                         MAX_WIDTH : gb5_pkg::SIZE_LIMIT;
    localparam int AW = $clog2(LINE_DEPTH);

    localparam int POS_W  = gb5_pkg::POS_W;
    localparam int SIZE_W = gb5_pkg::SIZE_W;

    // Configuration and position
    logic [SIZE_W-1:0] width_eff_reg, width_eff_next;
    logic [SIZE_W-1:0] height_eff_reg, height_eff_next;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [POS_W-1:0]  col_reg, col_next;
    logic              cfg_fire;
    logic              cfg_hit;
    logic              s_fire;

    // Pipeline
    logic                st1_valid_reg, st1_valid_next;
    logic                st2_valid_reg, st2_valid_next;
    logic                st3_valid_reg, st3_valid_next;
    logic                sent_int_reg, sent_int_next;
    gb5_pkg::item_t      st1_item_reg, st2_item_reg, st3_item_reg;
    gb5_pkg::item_t      new_item;
    logic                ready2, ready3;
    logic                move1, move2, st3_leave;

    gb5_pkg::line_word_t rd_word, wr_word;
    gb5_pkg::vsum_t      col_sum;
    gb5_pkg::hsum_t      acc_chain [gb5_pkg::TAPS+1];
    gb5_pkg::chan_t      quo;

    // Output selection
    logic                cur_int;
    logic                out_fire;
    logic [POS_W-1:0]    out_row, out_col;
    logic [gb5_pkg::PIX_W-1:0] out_pix;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign s_fire    = s_tvalid & s_tready;

    // Register writes: clamped on the way in
    always_comb begin
        width_eff_next  = width_eff_reg;
        height_eff_next = height_eff_reg;
        cfg_hit         = 1'b0;
        if (cfg_fire) begin
            case (cfg_index)
                gb5_pkg::REG_IMAGE_WIDTH: begin
                    width_eff_next = gb5_pkg::clamp_size(cfg_data, MAX_WIDTH);
                    cfg_hit        = 1'b1;
                end
                gb5_pkg::REG_IMAGE_HEIGHT: begin
                    height_eff_next = gb5_pkg::clamp_size(cfg_data, MAX_HEIGHT);
                    cfg_hit         = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // Raster position of the next pixel
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_hit) begin
            row_next = '0;
            col_next = '0;
        end else if (s_fire) begin
            if (SIZE_W'(col_reg) + SIZE_W'(1) >= width_eff_reg) begin
                col_next = '0;
                if (SIZE_W'(row_reg) + SIZE_W'(1) >= height_eff_reg) begin
                    row_next = '0;
                end else begin
                    row_next = row_reg + POS_W'(1);
                end
            end else begin
                col_next = col_reg + POS_W'(1);
            end
        end
    end

    // Classify the arriving pixel
    always_comb begin
        new_item.row    = row_reg;
        new_item.col    = col_reg;
        new_item.pix    = s_tdata[gb5_pkg::PIX_W-1:0];
        new_item.is_int = (width_eff_reg >= SIZE_W'(gb5_pkg::MIN_INTERIOR))
                       && (height_eff_reg >= SIZE_W'(gb5_pkg::MIN_INTERIOR))
                       && (row_reg >= POS_W'(4)) && (col_reg >= POS_W'(4));
        new_item.is_pt  = (row_reg < POS_W'(2)) || (col_reg < POS_W'(2))
                       || (SIZE_W'(row_reg) + SIZE_W'(2) >= height_eff_reg)
                       || (SIZE_W'(col_reg) + SIZE_W'(2) >= width_eff_reg);
    end

    // Stage handshakes: a stage takes a new item when empty or emptying
    assign st3_leave = st3_valid_reg && (!m_tvalid || (m_tready && m_tlast));
    assign ready3    = !st3_valid_reg || st3_leave;
    assign ready2    = !st2_valid_reg || ready3;
    assign s_tready  = !st1_valid_reg || ready2;
    assign move1     = st1_valid_reg && ready2;
    assign move2     = st2_valid_reg && ready3;

    always_comb begin
        st1_valid_next = st1_valid_reg;
        st2_valid_next = st2_valid_reg;
        st3_valid_next = st3_valid_reg;
        if (s_tready) begin
            st1_valid_next = s_fire;
        end
        if (ready2) begin
            st2_valid_next = st1_valid_reg;
        end
        if (ready3) begin
            st3_valid_next = st2_valid_reg;
        end
    end

    // Interior result of the held item goes out before its pass-through
    always_comb begin
        sent_int_next = sent_int_reg;
        if (ready3) begin
            sent_int_next = 1'b0;
        end else if (out_fire && !m_tlast) begin
            sent_int_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_eff_reg  <= gb5_pkg::clamp_size(SIZE_W'(gb5_pkg::WIDTH_RESET), MAX_WIDTH);
            height_eff_reg <= gb5_pkg::clamp_size(SIZE_W'(gb5_pkg::HEIGHT_RESET), MAX_HEIGHT);
            row_reg        <= '0;
            col_reg        <= '0;
            st1_valid_reg  <= 1'b0;
            st2_valid_reg  <= 1'b0;
            st3_valid_reg  <= 1'b0;
            sent_int_reg   <= 1'b0;
        end else begin
            width_eff_reg  <= width_eff_next;
            height_eff_reg <= height_eff_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            st1_valid_reg  <= st1_valid_next;
            st2_valid_reg  <= st2_valid_next;
            st3_valid_reg  <= st3_valid_next;
            sent_int_reg   <= sent_int_next;
        end
    end

    // Item payload along the stages
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st1_item_reg <= new_item;
        end
        if (move1) begin
            st2_item_reg <= st1_item_reg;
        end
        if (move2) begin
            st3_item_reg <= st2_item_reg;
        end
    end

    // Line store: read the column on transfer, push the new pixel in on the way out
    gb5_line_buf #(
        .DEPTH (LINE_DEPTH)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (s_fire),
        .rd_addr (col_reg[AW-1:0]),
        .rd_data (rd_word),
        .wr_en   (move1),
        .wr_addr (st1_item_reg.col[AW-1:0]),
        .wr_data (wr_word)
    );

    always_comb begin
        wr_word[0] = st1_item_reg.pix;
        for (int k = 1; k < gb5_pkg::LINE_ROWS; k++) begin
            wr_word[k] = rd_word[k-1];
        end
    end

    assign col_sum = gb5_pkg::vert_sum(st1_item_reg.pix, rd_word);

    // Row of tap cells, transposed form: the last cell holds the full window sum
    assign acc_chain[0] = '0;

    for (genvar k = 0; k < gb5_pkg::TAPS; k++) begin : g_tap
        gb5_cell #(
            .TAP_SHIFT (gb5_pkg::tap_shift(k))
        ) u_cell (
            .aclk    (aclk),
            .en      (move1),
            .acc_in  (acc_chain[k]),
            .v_in    (col_sum),
            .acc_out (acc_chain[k+1])
        );
    end

    gb5_scale u_scale (
        .aclk    (aclk),
        .en      (move2),
        .sum_in  (acc_chain[gb5_pkg::TAPS]),
        .quo_out (quo)
    );

    // Result selection
    assign cur_int  = st3_item_reg.is_int && !sent_int_reg;
    assign m_tvalid = st3_valid_reg && (cur_int || st3_item_reg.is_pt);
    assign m_tlast  = !(cur_int && st3_item_reg.is_pt);
    assign out_fire = m_tvalid && m_tready;

    assign out_row = cur_int ? st3_item_reg.row - POS_W'(2) : st3_item_reg.row;
    assign out_col = cur_int ? st3_item_reg.col - POS_W'(2) : st3_item_reg.col;
    assign out_pix = cur_int ? quo : st3_item_reg.pix;

    assign m_tdata = {{gb5_pkg::PAD_W{1'b0}}, out_pix, out_col, out_row};

`ifndef ASSERT_OFF
    // A non-final result is always followed by the pass-through of the same pixel
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |=> m_tvalid)
        else $error("second result of a pixel missing");

    // Interior results sit two or more away from the top and left edges
    a_int_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (out_row >= POS_W'(2)) && (out_col >= POS_W'(2)))
        else $error("interior result at an edge position");

    // The raster position stays inside the configured frame
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        SIZE_W'(col_reg) < width_eff_reg && SIZE_W'(row_reg) < height_eff_reg)
        else $error("raster position outside the frame");

    // Input stalls only when every stage is occupied
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> st1_valid_reg && st2_valid_reg && st3_valid_reg)
        else $error("input stalled with a free stage");
`endif

endmodule

// ----- tb/sv/gaussian_blur_5x5_window_tb.sv -----
// Self-checking testbench for the 5x5 Gaussian blur window: random frames, stalls and size changes.
module gaussian_blur_5x5_window_tb;

    localparam int unsigned LINE_DEPTH = 2048;     // columns kept per stored row
    localparam int          SETTLE     = 10;       // cycles for a pixel with no result to clear
    localparam int          LONG_HOLD  = 300;      // receiver hold-off used to back up the block
    localparam int          ITEM_COUNT = 1400;
    localparam int          MAX_SHOWN  = 10;
    localparam logic [gb5_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam logic [gb5_pkg::TAPS-1:0][2:0] TAP_WEIGHT   = {3'd1, 3'd2, 3'd4, 3'd2, 3'd1};

    // One result as it appears on the output channel
    typedef struct packed {
        logic [gb5_pkg::POS_W-1:0] row;
        logic [gb5_pkg::POS_W-1:0] col;
        logic [gb5_pkg::CH_W-1:0]  blue;
        logic [gb5_pkg::CH_W-1:0]  green;
        logic [gb5_pkg::CH_W-1:0]  red;
        logic                      last;
    } blur_result_t;

    logic                              aclk;
    logic                              aresetn   = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [gb5_pkg::S_TDATA_W-1:0]     s_tdata   = '0;    // pix_blue, pix_green, pix_red
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [gb5_pkg::M_TDATA_W-1:0]     m_tdata;  // out_row, out_col, out_blue, out_green, out_red
    logic                              m_tlast;           // last_of_run
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [gb5_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [gb5_pkg::SIZE_W-1:0]        cfg_data  = '0;

    // Stimulus and expectation stores
    logic [gb5_pkg::PIX_W-1:0]         pixel_q [$];
    blur_result_t                      blurred_q [$];

    // Predictor state
    logic [gb5_pkg::PIX_W-1:0]         line_mem [gb5_pkg::LINE_ROWS*LINE_DEPTH];
    logic [gb5_pkg::PIX_W-1:0]         recent_px [4];
    int unsigned                       pos_row    = 0;
    int unsigned                       pos_col    = 0;
    logic [gb5_pkg::SIZE_W-1:0]        width_reg  = gb5_pkg::SIZE_W'(gb5_pkg::WIDTH_RESET);
    logic [gb5_pkg::SIZE_W-1:0]        height_reg = gb5_pkg::SIZE_W'(gb5_pkg::HEIGHT_RESET);

    // Run control and statistics
    bit                     src_idle    = 1'b0;
    bit                     sink_idle   = 1'b0;
    int                     hold_request = 0;
    int                     pixels_queued = 0;
    int                     pixels_sent   = 0;
    int                     results_seen  = 0;
    int                     interior_seen = 0;
    int                     double_seen   = 0;
    int                     cfg_writes    = 0;
    int                     mismatches    = 0;

    gaussian_blur_5x5_window u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Effective frame dimension: zero acts as one, oversize saturates
    function automatic int unsigned frame_dim(input logic [gb5_pkg::SIZE_W-1:0] v);
        if (v == '0) begin
            return 1;
        end else if (32'(v) > LINE_DEPTH) begin
            return LINE_DEPTH;
        end
        return 32'(v);
    endfunction

    // Expected results of one accepted pixel, then advance the window state
    function automatic void blur_pixel(input logic [gb5_pkg::PIX_W-1:0] pix);
        int unsigned               w, h, r, c, orow, ocol, n;
        int unsigned               acc [3];
        int                        k, j, ch;
        logic [gb5_pkg::PIX_W-1:0] px;
        blur_result_t              found [2];
        w = frame_dim(width_reg);
        h = frame_dim(height_reg);
        r = pos_row;
        c = pos_col;
        n = 0;
        // interior pixel two rows up and two columns left completes here
        if (w >= 5 && h >= 5 && r >= 4 && c >= 4 && r < h && c < w) begin
            acc = '{0, 0, 0};
            for (k = 0; k < 5; k++) begin
                for (j = 0; j < 5; j++) begin
                    if (k == 4) begin
                        px = (j == 4) ? pix : recent_px[j];
                    end else begin
                        px = line_mem[((r - 4 + k) % 4) * LINE_DEPTH + (c - 4 + j)];
                    end
                    for (ch = 0; ch < gb5_pkg::CHANNELS; ch++) begin
                        acc[ch] += 32'(px[ch*gb5_pkg::CH_W +: gb5_pkg::CH_W])
                                 * 32'(TAP_WEIGHT[k]) * 32'(TAP_WEIGHT[j]);
                    end
                end
            end
            found[n].row   = gb5_pkg::POS_W'(r - 2);
            found[n].col   = gb5_pkg::POS_W'(c - 2);
            found[n].blue  = gb5_pkg::CH_W'(acc[0] / 100);
            found[n].green = gb5_pkg::CH_W'(acc[1] / 100);
            found[n].red   = gb5_pkg::CH_W'(acc[2] / 100);
            n++;
            interior_seen++;
        end
        // border pixel passes through as it arrives
        if (r < 2 || r + 2 >= h || c < 2 || c + 2 >= w) begin
            found[n].row   = gb5_pkg::POS_W'(r);
            found[n].col   = gb5_pkg::POS_W'(c);
            found[n].blue  = pix[0 +: gb5_pkg::CH_W];
            found[n].green = pix[gb5_pkg::CH_W +: gb5_pkg::CH_W];
            found[n].red   = pix[2*gb5_pkg::CH_W +: gb5_pkg::CH_W];
            n++;
        end
        if (n == 2) begin
            double_seen++;
        end
        for (k = 0; k < int'(n); k++) begin
            found[k].last = (k == int'(n) - 1);
            blurred_q.push_back(found[k]);
        end
        // oldest recent pixel retires into the line store
        if (w >= 5 && !(r == 0 && c < 4)) begin
            if (c >= 4) begin
                orow = r;
                ocol = c - 4;
            end else begin
                orow = r - 1;
                ocol = c + w - 4;
            end
            if (ocol < LINE_DEPTH) begin
                line_mem[(orow % 4) * LINE_DEPTH + ocol] = recent_px[0];
            end
        end
        recent_px[0] = recent_px[1];
        recent_px[1] = recent_px[2];
        recent_px[2] = recent_px[3];
        recent_px[3] = pix;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) begin
                r = 0;
            end
        end
        pos_col = c % LINE_DEPTH;
        pos_row = r % LINE_DEPTH;
    endfunction

    // Compare one output transfer against the oldest expectation
    task automatic check_result(input logic [gb5_pkg::M_TDATA_W-1:0] d, input logic last);
        blur_result_t got, want;
        got.row   = d[0 +: gb5_pkg::POS_W];
        got.col   = d[gb5_pkg::POS_W +: gb5_pkg::POS_W];
        got.blue  = d[2*gb5_pkg::POS_W +: gb5_pkg::CH_W];
        got.green = d[2*gb5_pkg::POS_W+gb5_pkg::CH_W +: gb5_pkg::CH_W];
        got.red   = d[2*gb5_pkg::POS_W+2*gb5_pkg::CH_W +: gb5_pkg::CH_W];
        got.last  = last;
        results_seen++;
        if (blurred_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
                $display("unexpected result: row %0d col %0d bgr %02h %02h %02h last %0b",
                         got.row, got.col, got.blue, got.green, got.red, got.last);
            end
        end else begin
            want = blurred_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("mismatch on result %0d", results_seen);
                    $display("  expected row %0d col %0d bgr %02h %02h %02h last %0b",
                             want.row, want.col, want.blue, want.green, want.red, want.last);
                    $display("  actual   row %0d col %0d bgr %02h %02h %02h last %0b",
                             got.row, got.col, got.blue, got.green, got.red, got.last);
                end
            end
        end
    endtask

    // Pixel driver: takes pending pixels, inserts a random gap after each transfer while src_idle is set
    int src_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                blur_pixel(s_tdata);
                pixels_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    s_tdata  <= pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    src_gap = src_idle ? $urandom_range(0, 9) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transfer, stalls at random, serves long hold-offs
    int sink_wait   = 0;
    int hold_left   = 0;
    int hold_served = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_wait = 0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata, m_tlast);
            end
            if (hold_served != hold_request) begin
                hold_served = hold_request;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (m_tready) begin
                if (m_tvalid) begin
                    sink_wait = sink_idle ? $urandom_range(0, 9) : 0;
                    if (sink_wait > 0) begin
                        m_tready <= 1'b0;
                    end
                end
            end else if (sink_wait > 1) begin
                sink_wait--;
            end else begin
                sink_wait = 0;
                m_tready <= 1'b1;
            end
        end
    end

    // Wait until every pixel is taken and every result is back, then let the pipe settle
    task automatic drain();
        do begin
            @(posedge aclk);
        end while (pixels_sent != pixels_queued || blurred_q.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // One register write; the block restarts its frame on a mapped index
    task automatic write_reg(input logic [gb5_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gb5_pkg::SIZE_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        if (idx == gb5_pkg::REG_IMAGE_WIDTH) begin
            width_reg = val;
            pos_row   = 0;
            pos_col   = 0;
        end else if (idx == gb5_pkg::REG_IMAGE_HEIGHT) begin
            height_reg = val;
            pos_row    = 0;
            pos_col    = 0;
        end
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        drain();
        write_reg(gb5_pkg::REG_IMAGE_WIDTH, gb5_pkg::SIZE_W'(w));
        write_reg(gb5_pkg::REG_IMAGE_HEIGHT, gb5_pkg::SIZE_W'(h));
    endtask

    task automatic feed_random(input int unsigned n);
        repeat (n) pixel_q.push_back(gb5_pkg::PIX_W'($urandom));
        pixels_queued += int'(n);
    endtask

    // Stimulus sequence
    initial begin : stimulus
        int unsigned w, h, n, kind, phase;
        bit          pause;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset size: a few extreme pixels on the top row
        pixel_q.push_back(24'h000000);
        pixel_q.push_back(24'hFFFFFF);
        pixel_q.push_back(24'h3CA55A);
        pixels_queued += 3;

        // smallest frame with an interior: one blurred pixel at full scale, a pixel with
        // no result, a pixel with two results, then the wrap into the next frame
        set_frame(5, 5);
        repeat (25) pixel_q.push_back(24'hFFFFFF);
        pixel_q.push_back(24'h000000);
        pixel_q.push_back(24'h00FF00);
        pixels_queued += 27;

        // zero sizes act as a 1x1 frame
        set_frame(0, 0);
        feed_random(3);

        // oversize and full-size settings, kept short
        set_frame(4095, 4095);
        feed_random(30);
        set_frame(2048, 5);
        feed_random(20);
        set_frame(5, 4095);
        feed_random(40);

        // unmapped register: no restart, the frame carries on
        drain();
        write_reg(REG_UNMAPPED, 12'hFFF);
        feed_random(20);

        // frame too narrow for an interior
        set_frame(3, 7);
        feed_random(23);

        // random frames, mostly whole frames of small sizes
        phase = 0;
        while (pixels_queued < ITEM_COUNT) begin
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            kind = (phase == 0) ? 0 : $urandom_range(0, 9);
            if (kind <= 5) begin
                w = $urandom_range(5, 12);
                h = $urandom_range(5, 9);
                set_frame(w, h);
                n = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
            end else if (kind == 6) begin
                w = $urandom_range(1, 4);
                h = $urandom_range(1, 12);
                if ($urandom_range(0, 1) == 1) begin
                    set_frame(h, w);
                end else begin
                    set_frame(w, h);
                end
                n = w * h + $urandom_range(0, 6);
            end else if (kind == 7) begin
                // restart mid-frame through the width register alone
                drain();
                write_reg(gb5_pkg::REG_IMAGE_WIDTH, gb5_pkg::SIZE_W'($urandom_range(5, 10)));
                n = $urandom_range(10, 60);
            end else if (kind == 8) begin
                w = $urandom_range(5, 8);
                h = $urandom_range(2049, 4095);
                set_frame(w, h);
                n = $urandom_range(40, 100);
            end else begin
                w = $urandom_range(13, 40);
                h = $urandom_range(5, 7);
                set_frame(w, h);
                n = w * 5 + $urandom_range(0, 10);
            end
            pause = (phase == 1) || ($urandom_range(0, 5) == 0);
            feed_random(n / 2);
            // receiver holds off while the sender keeps offering
            if (phase == 0 || $urandom_range(0, 7) == 0) begin
                hold_request++;
            end
            if (pause) begin
                drain();
            end
            feed_random(n - n / 2);
            phase++;
        end

        drain();
        $display("fed %0d pixels over %0d register writes; %0d results checked",
                 pixels_sent, cfg_writes, results_seen);
        $display("%0d blurred interior pixels, %0d pixels giving two results",
                 interior_seen, double_seen);
        if (mismatches == 0 && blurred_q.size() == 0) begin
            $display("gaussian_blur_5x5_window_tb OK");
        end else begin
            $display("gaussian_blur_5x5_window_tb NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1000000;
        $display("timed out with %0d results outstanding", blurred_q.size());
        $display("gaussian_blur_5x5_window_tb NOT OK");
        $finish;
    end

endmodule
